// ===== rtl/core/oets_pkg.sv =====
// Shared constants for the odd-even transposition sorter.
// No dependencies; imported by the top level and its checker.
`default_nettype none

package oets_pkg;

  // Width of the key ports.
  localparam int KEY_W = 16;

  // Parameter defaults.
  localparam int MAX_KEYS_DEF = 64;
  localparam int KEY_BITS_DEF = 16;

endpackage

`default_nettype wire

// ===== rtl/core/odd_even_transposition_sort.sv =====
// Odd-even transposition sorter: top level with key memory and compare sequencer.
// Depends on oets_pkg.
`default_nettype none

// - Input channel (in_valid / in_stall, key_in, final_key): one key per word.
//   Keys are stored in arrival order. A word with final_key set, or the
//   MAX_KEYS-th word of a set, closes the set and starts the sort.
// - Output channel (out_valid / out_stall, key_out, end_of_set): the set comes
//   back ascending, one key per word; end_of_set marks the last one. Equal keys
//   keep their arrival order.
// - Loading writes each accepted key into the key memory. Sorting uses one
//   two-read-port memory and one comparator: each compare reads the pair
//   (S_RD), compares it and, on a swap, writes the left key (S_CMP), then
//   writes the right key (S_WR2); S_CHK picks the next pair, phase or round.
//   At most about n/2 + 1 rounds run over n keys. Unloading reads each key
//   from memory (S_ORD), then loads it into the output register (S_OLD).
// - A set of one key goes straight from the closing word to unloading, unsorted.
// - in_stall is high from the closing word until the last sorted key has been
//   loaded into the output register; the next set may start loading while
//   that last word still waits.
// - If the receiver stalls, the output register holds its word and the
//   unload sequencer waits on it.
// - Reset (rst, synchronous) empties the set and the output register; the key
//   memory is not cleared, as only entries written in the current set are read.
module odd_even_transposition_sort
  import oets_pkg::*;
#(
  parameter int MAX_KEYS = MAX_KEYS_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [KEY_W-1:0] key_in,
  input  wire logic             final_key,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic      [KEY_W-1:0] key_out,
  output logic                  end_of_set
);

  // Stored key width: keys are cut to KEY_BITS and never exceed the port.
  localparam int SW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CW = $clog2(MAX_KEYS + 1);

  typedef enum logic [6:0] {
    S_LOAD = 7'b0000001,  // taking keys
    S_CHK  = 7'b0000010,  // pick next pair, phase or round
    S_RD   = 7'b0000100,  // read pair from memory
    S_CMP  = 7'b0001000,  // compare, write left on swap
    S_WR2  = 7'b0010000,  // write right on swap
    S_ORD  = 7'b0100000,  // read key to emit
    S_OLD  = 7'b1000000   // load output register
  } state_t;

  // Key memory
  logic [SW-1:0] key_store [MAX_KEYS];
  logic [SW-1:0] rd_a, rd_b;

  // Control registers
  state_t        state, state_next;
  logic [CW-1:0] count, count_next;   // keys in set
  logic [CW-1:0] idx, idx_next;       // left index of current pair
  logic [CW-1:0] oidx, oidx_next;     // unload index
  logic          phase, phase_next;   // 0 odd pairs, 1 even pairs
  logic          swap_seen, swap_next;

  // Memory port controls
  logic          we;
  logic [AW-1:0] waddr;
  logic [SW-1:0] wdata;
  logic          re;
  logic [AW-1:0] raddr_a, raddr_b;

  logic          in_acc;
  logic          out_free;
  logic [CW:0]   idx_p1;
  logic [CW-1:0] idx_p2;
  logic [CW-1:0] count_p1;
  logic          oidx_last;

  assign in_stall  = (state != S_LOAD);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign idx_p1    = {1'b0, idx} + 1'b1;
  assign idx_p2    = idx + CW'(2);
  assign count_p1  = count + 1'b1;
  assign oidx_last = ((oidx + 1'b1) == count);

  always_comb begin
    state_next = state;
    count_next = count;
    idx_next   = idx;
    oidx_next  = oidx;
    phase_next = phase;
    swap_next  = swap_seen;
    we         = 1'b0;
    waddr      = idx[AW-1:0];
    wdata      = rd_b;
    re         = 1'b0;
    raddr_a    = idx[AW-1:0];
    raddr_b    = idx_p1[AW-1:0];

    unique case (state)
      S_LOAD: begin
        if (in_acc) begin
          we         = 1'b1;
          waddr      = count[AW-1:0];
          wdata      = key_in[SW-1:0];
          count_next = count_p1;
          if (final_key || (count_p1 == CW'(MAX_KEYS))) begin
            if (count_p1 == CW'(1)) begin
              // single key: emit at once
              oidx_next  = '0;
              state_next = S_ORD;
            end else begin
              idx_next   = CW'(1);
              phase_next = 1'b0;
              swap_next  = 1'b0;
              state_next = S_CHK;
            end
          end
        end
      end
      S_CHK: begin
        if (idx_p1 < {1'b0, count}) begin
          state_next = S_RD;
        end else if (!phase) begin
          phase_next = 1'b1;
          idx_next   = '0;
        end else if (swap_seen) begin
          // another round
          swap_next  = 1'b0;
          phase_next = 1'b0;
          idx_next   = CW'(1);
        end else begin
          phase_next = 1'b0;
          oidx_next  = '0;
          state_next = S_ORD;
        end
      end
      S_RD: begin
        re         = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (rd_a > rd_b) begin
          we         = 1'b1;
          waddr      = idx[AW-1:0];
          wdata      = rd_b;
          swap_next  = 1'b1;
          state_next = S_WR2;
        end else begin
          idx_next   = idx_p2;
          state_next = S_CHK;
        end
      end
      S_WR2: begin
        we         = 1'b1;
        waddr      = idx_p1[AW-1:0];
        wdata      = rd_a;
        idx_next   = idx_p2;
        state_next = S_CHK;
      end
      S_ORD: begin
        re         = 1'b1;
        raddr_a    = oidx[AW-1:0];
        state_next = S_OLD;
      end
      S_OLD: begin
        if (out_free) begin
          if (oidx_last) begin
            count_next = '0;
            swap_next  = 1'b0;
            state_next = S_LOAD;
          end else begin
            oidx_next  = oidx + 1'b1;
            state_next = S_ORD;
          end
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  // Memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      key_store[waddr] <= wdata;
    end
    if (re) begin
      rd_a <= key_store[raddr_a];
      rd_b <= key_store[raddr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      idx       <= '0;
      oidx      <= '0;
      phase     <= 1'b0;
      swap_seen <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      idx       <= idx_next;
      oidx      <= oidx_next;
      phase     <= phase_next;
      swap_seen <= swap_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OLD && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OLD && out_free) begin
      key_out    <= KEY_W'(rd_a);
      end_of_set <= oidx_last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/oets_checker.sv =====
// Port-level checks for the odd-even transposition sorter, bound to the top.
// Depends on oets_pkg.
`default_nettype none

module oets_checker
  import oets_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_valid,
  input wire logic             in_stall,
  input wire logic [KEY_W-1:0] key_in,
  input wire logic             final_key,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [KEY_W-1:0] key_out,
  input wire logic             end_of_set
);

  // a word with final_key set always stops the input side next cycle
  a_close_stalls: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && final_key |=> in_stall)
    else $error("input not stalled after closing word");

  // keys are only taken while no mid-set result is pending
  a_load_vs_unload: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |-> !out_valid || end_of_set)
    else $error("key taken while a set is still unloading");

  // output register is empty after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(key_out) && $stable(end_of_set))
    else $error("stalled output word changed");

  // stalled input word holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(key_in) && $stable(final_key))
    else $error("stalled input word changed");

endmodule

bind odd_even_transposition_sort oets_checker u_oets_checker (.*);

`default_nettype wire
